[rtl/core/assert_macros.svh]
// assertion helpers used by the checker file fjst_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

[rtl/core/fjst_pkg.sv]
package fjst_pkg;

    // result kinds
    localparam logic [3:0] KIND_KEY_CHAR  = 4'd0;
    localparam logic [3:0] KIND_VAL_CHAR  = 4'd1;
    localparam logic [3:0] KIND_ELEM_CHAR = 4'd2;
    localparam logic [3:0] KIND_KEY_END   = 4'd3;
    localparam logic [3:0] KIND_VAL_END   = 4'd4;
    localparam logic [3:0] KIND_ELEM_END  = 4'd5;
    localparam logic [3:0] KIND_ARR_END   = 4'd6;
    localparam logic [3:0] KIND_ACCEPT    = 4'd7;
    localparam logic [3:0] KIND_REJECT    = 4'd8;

    // input actions
    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_EOS  = 1'b1;

    // syntax characters
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_R  = 8'h72;

    typedef struct packed {
        logic       action;
        logic [7:0] char_code;
    } fjst_item_t;

    typedef struct packed {
        logic       emit;
        logic [3:0] kind;
        logic [7:0] data;
    } fjst_res_t;

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c >= CH_TAB && c <= CH_CR) || (c == CH_SPACE);
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        case (c)
            CH_LOW_N: unescape = CH_LF;
            CH_LOW_T: unescape = CH_TAB;
            CH_LOW_R: unescape = CH_CR;
            default:  unescape = c;
        endcase
    endfunction

endpackage

[rtl/core/fjst_in_reg.sv]
module fjst_in_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    input  logic [7:0]          s_char_code,
    input  logic                take,
    output logic                item_valid,
    output fjst_pkg::fjst_item_t item
);

    logic                 valid_reg;
    logic                 valid_next;
    fjst_pkg::fjst_item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= '{action: s_action, char_code: s_char_code};
        end
    end

endmodule

[rtl/core/fjst_parser.sv]
module fjst_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  fjst_pkg::fjst_item_t item,
    output fjst_pkg::fjst_res_t  res
);

    typedef enum logic [13:0] {
        PH_SEEK_OPEN   = 14'h0001,
        PH_KEY_OR_END  = 14'h0002,
        PH_KEY         = 14'h0004,
        PH_KEY_ESC     = 14'h0008,
        PH_COLON       = 14'h0010,
        PH_VAL_START   = 14'h0020,
        PH_VAL         = 14'h0040,
        PH_VAL_ESC     = 14'h0080,
        PH_ELEM_OR_END = 14'h0100,
        PH_ELEM        = 14'h0200,
        PH_ELEM_ESC    = 14'h0400,
        PH_AFTER_ELEM  = 14'h0800,
        PH_AFTER_VAL   = 14'h1000,
        PH_DONE        = 14'h2000
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] c;
    logic       ws;

    assign c  = item.char_code;
    assign ws = fjst_pkg::is_ws(c);

    always_comb begin
        phase_next = phase_reg;
        res        = '{emit: 1'b0, kind: fjst_pkg::KIND_REJECT, data: 8'h00};
        if (step_en) begin
            if (item.action == fjst_pkg::ACT_EOS) begin
                // re-arm; reject only if no verdict was given yet
                phase_next = PH_SEEK_OPEN;
                res.emit   = (phase_reg != PH_DONE);
            end else begin
                unique case (phase_reg)
                    PH_SEEK_OPEN: begin
                        if (!ws) begin
                            if (c == fjst_pkg::CH_LBRACE) begin
                                phase_next = PH_KEY_OR_END;
                            end else begin
                                phase_next = PH_DONE;
                                res.emit   = 1'b1;
                            end
                        end
                    end
                    PH_KEY_OR_END: begin
                        if (!ws) begin
                            if (c == fjst_pkg::CH_QUOTE) begin
                                phase_next = PH_KEY;
                            end else begin
                                phase_next = PH_DONE;
                                res.emit   = 1'b1;
                                if (c == fjst_pkg::CH_RBRACE) begin
                                    res.kind = fjst_pkg::KIND_ACCEPT;
                                end
                            end
                        end
                    end
                    PH_KEY: begin
                        if (c == fjst_pkg::CH_QUOTE) begin
                            phase_next = PH_COLON;
                            res        = '{1'b1, fjst_pkg::KIND_KEY_END, 8'h00};
                        end else if (c == fjst_pkg::CH_BSLASH) begin
                            phase_next = PH_KEY_ESC;
                        end else begin
                            res = '{1'b1, fjst_pkg::KIND_KEY_CHAR, c};
                        end
                    end
                    PH_KEY_ESC: begin
                        phase_next = PH_KEY;
                        res        = '{1'b1, fjst_pkg::KIND_KEY_CHAR, fjst_pkg::unescape(c)};
                    end
                    PH_COLON: begin
                        if (!ws) begin
                            if (c == fjst_pkg::CH_COLON) begin
                                phase_next = PH_VAL_START;
                            end else begin
                                phase_next = PH_DONE;
                                res.emit   = 1'b1;
                            end
                        end
                    end
                    PH_VAL_START: begin
                        if (!ws) begin
                            if (c == fjst_pkg::CH_QUOTE) begin
                                phase_next = PH_VAL;
                            end else if (c == fjst_pkg::CH_LBRACK) begin
                                phase_next = PH_ELEM_OR_END;
                            end else begin
                                phase_next = PH_DONE;
                                res.emit   = 1'b1;
                            end
                        end
                    end
                    PH_VAL: begin
                        if (c == fjst_pkg::CH_QUOTE) begin
                            phase_next = PH_AFTER_VAL;
                            res        = '{1'b1, fjst_pkg::KIND_VAL_END, 8'h00};
                        end else if (c == fjst_pkg::CH_BSLASH) begin
                            phase_next = PH_VAL_ESC;
                        end else begin
                            res = '{1'b1, fjst_pkg::KIND_VAL_CHAR, c};
                        end
                    end
                    PH_VAL_ESC: begin
                        phase_next = PH_VAL;
                        res        = '{1'b1, fjst_pkg::KIND_VAL_CHAR, fjst_pkg::unescape(c)};
                    end
                    PH_ELEM_OR_END, PH_AFTER_ELEM: begin
                        // empty array or trailing comma closes like a normal end
                        if (!ws) begin
                            if (c == fjst_pkg::CH_RBRACK) begin
                                phase_next = PH_AFTER_VAL;
                                res        = '{1'b1, fjst_pkg::KIND_ARR_END, 8'h00};
                            end else if (phase_reg == PH_ELEM_OR_END
                                         && c == fjst_pkg::CH_QUOTE) begin
                                phase_next = PH_ELEM;
                            end else if (phase_reg == PH_AFTER_ELEM
                                         && c == fjst_pkg::CH_COMMA) begin
                                phase_next = PH_ELEM_OR_END;
                            end else begin
                                phase_next = PH_DONE;
                                res.emit   = 1'b1;
                            end
                        end
                    end
                    PH_ELEM: begin
                        if (c == fjst_pkg::CH_QUOTE) begin
                            phase_next = PH_AFTER_ELEM;
                            res        = '{1'b1, fjst_pkg::KIND_ELEM_END, 8'h00};
                        end else if (c == fjst_pkg::CH_BSLASH) begin
                            phase_next = PH_ELEM_ESC;
                        end else begin
                            res = '{1'b1, fjst_pkg::KIND_ELEM_CHAR, c};
                        end
                    end
                    PH_ELEM_ESC: begin
                        phase_next = PH_ELEM;
                        res        = '{1'b1, fjst_pkg::KIND_ELEM_CHAR, fjst_pkg::unescape(c)};
                    end
                    PH_AFTER_VAL: begin
                        if (!ws) begin
                            if (c == fjst_pkg::CH_COMMA) begin
                                phase_next = PH_KEY_OR_END;
                            end else begin
                                phase_next = PH_DONE;
                                res.emit   = 1'b1;
                                if (c == fjst_pkg::CH_RBRACE) begin
                                    res.kind = fjst_pkg::KIND_ACCEPT;
                                end
                            end
                        end
                    end
                    default: begin
                        // verdict given: characters are dropped
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SEEK_OPEN;
        end else begin
            phase_reg <= phase_next;
        end
    end

endmodule

[rtl/core/fjst_out_reg.sv]
module fjst_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  fjst_pkg::fjst_res_t res,
    output logic                free,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [3:0]          m_kind,
    output logic [7:0]          m_decoded_char
);

    logic       valid_reg;
    logic       valid_next;
    logic [3:0] kind_reg;
    logic [7:0] data_reg;

    assign free           = !valid_reg || m_ready;
    assign m_valid        = valid_reg;
    assign m_kind         = kind_reg;
    assign m_decoded_char = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = res.emit;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res.emit) begin
            kind_reg <= res.kind;
            data_reg <= res.data;
        end
    end

endmodule

[rtl/core/flat_json_string_tokenizer.sv]
// channel   direction  ports                                  meaning
// s_        in         s_valid s_ready s_action s_char_code   byte or end of stream
// m_        out        m_valid m_ready m_kind m_decoded_char  token char, mark or verdict
//
// one byte per cycle sustained while m_ready is high: input register, parser, result register
// a byte passes the input register, then the result register; a byte may give no result
// aresetn (synchronous) returns the parser to seeking the opening brace
// a stalled result register holds the parser and, once the input register is full, s_ready
module flat_json_string_tokenizer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_char_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_kind,
    output logic [7:0] m_decoded_char
);

    logic                 item_valid;
    fjst_pkg::fjst_item_t item;
    fjst_pkg::fjst_res_t  res;
    logic                 out_free;
    logic                 step_en;

    assign step_en = item_valid && out_free;

    fjst_in_reg u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_char_code (s_char_code),
        .take        (step_en),
        .item_valid  (item_valid),
        .item        (item)
    );

    fjst_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (item),
        .res     (res)
    );

    fjst_out_reg u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (step_en),
        .res            (res),
        .free           (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_decoded_char (m_decoded_char)
    );

endmodule

[rtl/core/fjst_checker.sv]
`include "assert_macros.svh"

module fjst_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_action,
    input logic [7:0] s_char_code,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_kind,
    input logic [7:0] m_decoded_char
);

    // a held result must not change under back-pressure
    `ASSERT_PROP(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_decoded_char), "result changed while stalled")

    // input side only stalls when a result is waiting and blocked
    `ASSERT_PROP(a_stall_cause, aclk, aresetn, !s_ready |-> m_valid && !m_ready, "input stalled without output back-pressure")

    // marks and verdicts carry no character
    `ASSERT_NEVER(a_mark_zero, aclk, aresetn, m_valid && m_kind != fjst_pkg::KIND_KEY_CHAR && m_kind != fjst_pkg::KIND_VAL_CHAR && m_kind != fjst_pkg::KIND_ELEM_CHAR && m_decoded_char != 8'h00, "mark with non-zero character")

    // kind code stays within the defined set
    `ASSERT_NEVER(a_kind_range, aclk, aresetn, m_valid && m_kind > fjst_pkg::KIND_REJECT, "undefined result kind")

    // nothing is presented straight after reset
    `ASSERT_PROP(a_reset_empty, aclk, aresetn, $past(!aresetn) |-> !m_valid, "result valid after reset")

endmodule

bind flat_json_string_tokenizer fjst_checker u_fjst_checker (.*);

[bench/fjst_token_checker.sv]
`timescale 1ns / 1ps

module fjst_token_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_char_code,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [3:0] m_kind,
    input  logic [7:0] m_decoded_char,
    output int         error_count,
    output int         tokens_owed
);
    import fjst_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef enum logic [3:0] {
        P_SEEK_OPEN, P_KEY_OR_END, P_KEY, P_KEY_ESC, P_COLON, P_VAL_START, P_VAL,
        P_VAL_ESC, P_ELEM_OR_END, P_ELEM, P_ELEM_ESC, P_AFTER_ELEM, P_AFTER_VAL, P_DONE
    } phase_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] ch;
    } token_t;

    phase_t phase = P_SEEK_OPEN;
    token_t owed_q[$];

    initial begin
        error_count = 0;
        tokens_owed = 0;
    end

    function automatic bit blank(input logic [7:0] c);
        return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
    endfunction

    function automatic logic [7:0] escaped(input logic [7:0] c);
        if (c == CH_LOW_N) return CH_LF;
        if (c == CH_LOW_T) return CH_TAB;
        if (c == CH_LOW_R) return CH_CR;
        return c;
    endfunction

    function automatic bit close_doc(input logic [3:0] kind, output token_t tok);
        phase = P_DONE;
        tok = '{kind, 8'h00};
        return 1'b1;
    endfunction

    // body byte of a key, value or element string
    function automatic bit string_char(input logic [7:0] c, input phase_t esc_ph,
                                       input phase_t done_ph, input logic [3:0] char_kind,
                                       input logic [3:0] end_kind, output token_t tok);
        tok = '0;
        if (c == CH_QUOTE) begin
            phase = done_ph;
            tok = '{end_kind, 8'h00};
            return 1'b1;
        end
        if (c == CH_BSLASH) begin
            phase = esc_ph;
            return 1'b0;
        end
        tok = '{char_kind, c};
        return 1'b1;
    endfunction

    function automatic bit predict_token(input logic act, input logic [7:0] c,
                                         output token_t tok);
        bit hit;
        hit = 1'b0;
        tok = '0;
        if (act == ACT_EOS) begin
            hit = (phase != P_DONE);
            if (hit) tok = '{KIND_REJECT, 8'h00};
            phase = P_SEEK_OPEN;
            return hit;
        end
        case (phase)
            P_SEEK_OPEN:
                if (c == CH_LBRACE) phase = P_KEY_OR_END;
                else if (!blank(c)) hit = close_doc(KIND_REJECT, tok);
            P_KEY_OR_END:
                if (c == CH_RBRACE) hit = close_doc(KIND_ACCEPT, tok);
                else if (c == CH_QUOTE) phase = P_KEY;
                else if (!blank(c)) hit = close_doc(KIND_REJECT, tok);
            P_KEY:
                hit = string_char(c, P_KEY_ESC, P_COLON, KIND_KEY_CHAR, KIND_KEY_END, tok);
            P_KEY_ESC: begin
                phase = P_KEY;
                tok = '{KIND_KEY_CHAR, escaped(c)};
                hit = 1'b1;
            end
            P_COLON:
                if (c == CH_COLON) phase = P_VAL_START;
                else if (!blank(c)) hit = close_doc(KIND_REJECT, tok);
            P_VAL_START:
                if (c == CH_QUOTE) phase = P_VAL;
                else if (c == CH_LBRACK) phase = P_ELEM_OR_END;
                else if (!blank(c)) hit = close_doc(KIND_REJECT, tok);
            P_VAL:
                hit = string_char(c, P_VAL_ESC, P_AFTER_VAL, KIND_VAL_CHAR, KIND_VAL_END, tok);
            P_VAL_ESC: begin
                phase = P_VAL;
                tok = '{KIND_VAL_CHAR, escaped(c)};
                hit = 1'b1;
            end
            P_ELEM_OR_END:
                if (c == CH_RBRACK) begin
                    phase = P_AFTER_VAL;
                    tok = '{KIND_ARR_END, 8'h00};
                    hit = 1'b1;
                end else if (c == CH_QUOTE) phase = P_ELEM;
                else if (!blank(c)) hit = close_doc(KIND_REJECT, tok);
            P_ELEM:
                hit = string_char(c, P_ELEM_ESC, P_AFTER_ELEM, KIND_ELEM_CHAR, KIND_ELEM_END,
                                  tok);
            P_ELEM_ESC: begin
                phase = P_ELEM;
                tok = '{KIND_ELEM_CHAR, escaped(c)};
                hit = 1'b1;
            end
            P_AFTER_ELEM:
                if (c == CH_RBRACK) begin
                    phase = P_AFTER_VAL;
                    tok = '{KIND_ARR_END, 8'h00};
                    hit = 1'b1;
                end else if (c == CH_COMMA) phase = P_ELEM_OR_END;
                else if (!blank(c)) hit = close_doc(KIND_REJECT, tok);
            P_AFTER_VAL:
                if (c == CH_RBRACE) hit = close_doc(KIND_ACCEPT, tok);
                else if (c == CH_COMMA) phase = P_KEY_OR_END;
                else if (!blank(c)) hit = close_doc(KIND_REJECT, tok);
            default: ;
        endcase
        return hit;
    endfunction

    always @(posedge aclk) begin : watch
        token_t want;
        token_t got;
        token_t next_tok;
        if (!aresetn) begin
            phase = P_SEEK_OPEN;
            owed_q.delete();
        end else begin
            // result side first: a byte accepted on this edge cannot have a result yet
            if (m_valid && m_ready) begin
                got = '{m_kind, m_decoded_char};
                if (owed_q.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: unexpected token kind=%0d char=%02h",
                                 $time, got.kind, got.ch);
                end else begin
                    want = owed_q.pop_front();
                    if (got.kind !== want.kind || got.ch !== want.ch) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("%0t: expected kind=%0d char=%02h, got kind=%0d char=%02h",
                                     $time, want.kind, want.ch, got.kind, got.ch);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (predict_token(s_action, s_char_code, next_tok))
                    owed_q.insert(owed_q.size(), next_tok);
            end
        end
        tokens_owed = owed_q.size();
    end

endmodule

[bench/flat_json_string_tokenizer_test.sv]
`timescale 1ns / 1ps

module flat_json_string_tokenizer_test;
    import fjst_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int CALM_TAIL    = 200;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN        = 8;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum {DOC_CLEAN, DOC_TRUNCATED, DOC_CORRUPT, DOC_NOISE} doc_mode_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_action;
    logic [7:0] s_char_code;
    logic       m_valid;
    logic       m_ready;
    logic [3:0] m_kind;
    logic [7:0] m_decoded_char;

    int error_count;
    int tokens_owed;
    int cycle_count = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    bit holding = 1'b0;

    fjst_item_t byte_feed[$];
    logic [7:0] doc_buf[$];

    flat_json_string_tokenizer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_char_code    (s_char_code),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_decoded_char (m_decoded_char)
    );

    fjst_token_checker token_watch (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_char_code    (s_char_code),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_decoded_char (m_decoded_char),
        .error_count    (error_count),
        .tokens_owed    (tokens_owed)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void put(input logic act, input logic [7:0] c);
        fjst_item_t it;
        it.action    = act;
        it.char_code = c;
        byte_feed.insert(byte_feed.size(), it);
    endfunction

    function automatic void add_byte(input logic [7:0] c);
        doc_buf.insert(doc_buf.size(), c);
    endfunction

    // optional whitespace between tokens
    function automatic void pad();
        int n;
        int k;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n) begin
            k = $urandom_range(9, 14);
            add_byte((k == 14) ? CH_SPACE : 8'(k));
        end
    endfunction

    // quoted string with random bytes and escapes
    function automatic void text();
        int len;
        logic [7:0] c;
        len = $urandom_range(0, 5);
        add_byte(CH_QUOTE);
        repeat (len) begin
            if ($urandom_range(0, 4) == 0) begin
                add_byte(CH_BSLASH);
                case ($urandom_range(0, 5))
                    0: c = CH_LOW_N;
                    1: c = CH_LOW_T;
                    2: c = CH_LOW_R;
                    3: c = CH_QUOTE;
                    4: c = CH_BSLASH;
                    default: c = 8'($urandom);
                endcase
            end else begin
                do c = 8'($urandom); while (c == CH_QUOTE || c == CH_BSLASH);
            end
            add_byte(c);
        end
        add_byte(CH_QUOTE);
    endfunction

    function automatic void build_object();
        int pairs;
        int elems;
        doc_buf.delete();
        pad();
        add_byte(CH_LBRACE);
        pad();
        pairs = $urandom_range(0, 3);
        for (int p = 0; p < pairs; p++) begin
            text();
            pad();
            add_byte(CH_COLON);
            pad();
            if ($urandom_range(0, 1)) text();
            else begin
                add_byte(CH_LBRACK);
                pad();
                elems = $urandom_range(0, 3);
                for (int e = 0; e < elems; e++) begin
                    text();
                    pad();
                    // trailing comma now and then
                    if (e < elems - 1 || $urandom_range(0, 3) == 0) begin
                        add_byte(CH_COMMA);
                        pad();
                    end
                end
                add_byte(CH_RBRACK);
            end
            pad();
            if (p < pairs - 1 || $urandom_range(0, 3) == 0) begin
                add_byte(CH_COMMA);
                pad();
            end
        end
        add_byte(CH_RBRACE);
    endfunction

    function automatic void queue_doc(input doc_mode_t mode);
        int cut;
        cut = doc_buf.size();
        case (mode)
            DOC_TRUNCATED: cut = $urandom_range(0, doc_buf.size() - 1);
            DOC_CORRUPT:   doc_buf[$urandom_range(0, doc_buf.size() - 1)] = 8'($urandom);
            DOC_NOISE: begin
                doc_buf.delete();
                repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
                cut = doc_buf.size();
            end
            default: ;
        endcase
        for (int i = 0; i < cut; i++) put(ACT_CHAR, doc_buf[i]);
        // bytes after the verdict should be dropped
        if (mode == DOC_CLEAN && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) put(ACT_CHAR, 8'($urandom));
        put(ACT_EOS, 8'($urandom));
    endfunction

    task automatic send(input fjst_item_t it);
        if (!calm && !holding && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_action = it.action;
        s_char_code = it.char_code;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin : result_sink
        int n;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                // long stall so the pipeline fills and backs up the input
                hold_req = 1'b0;
                holding = 1'b1;
                m_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                holding = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                n = $urandom_range(1, 5);
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    initial begin : stimulus
        int n_directed;
        int r;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = ACT_CHAR;
        s_char_code = 8'h00;

        // empty object, then a byte and end of stream after the verdict
        put(ACT_CHAR, CH_LBRACE);
        put(ACT_CHAR, CH_RBRACE);
        put(ACT_CHAR, 8'hFF);
        put(ACT_EOS, 8'h00);
        // escaped key, high byte element, trailing commas in array and object
        put(ACT_CHAR, CH_TAB);
        put(ACT_CHAR, CH_LBRACE);
        put(ACT_CHAR, CH_QUOTE);
        put(ACT_CHAR, CH_BSLASH);
        put(ACT_CHAR, CH_LOW_N);
        put(ACT_CHAR, CH_QUOTE);
        put(ACT_CHAR, CH_COLON);
        put(ACT_CHAR, CH_LBRACK);
        put(ACT_CHAR, CH_QUOTE);
        put(ACT_CHAR, 8'h80);
        put(ACT_CHAR, CH_QUOTE);
        put(ACT_CHAR, CH_COMMA);
        put(ACT_CHAR, CH_RBRACK);
        put(ACT_CHAR, CH_COMMA);
        put(ACT_CHAR, CH_RBRACE);
        put(ACT_EOS, 8'hFF);
        // end of stream inside an escape
        put(ACT_CHAR, CH_LBRACE);
        put(ACT_CHAR, CH_QUOTE);
        put(ACT_CHAR, CH_BSLASH);
        put(ACT_EOS, 8'h00);
        // stray byte where the brace belongs
        put(ACT_CHAR, 8'h00);
        put(ACT_EOS, 8'h00);
        n_directed = byte_feed.size();

        while (byte_feed.size() < n_directed + RANDOM_ITEMS) begin
            build_object();
            r = $urandom_range(0, 19);
            if (r < 14) queue_doc(DOC_CLEAN);
            else if (r < 16) queue_doc(DOC_TRUNCATED);
            else if (r < 18) queue_doc(DOC_CORRUPT);
            else queue_doc(DOC_NOISE);
        end

        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < byte_feed.size(); i++) begin
            calm = (i >= byte_feed.size() - CALM_TAIL);
            if (i == n_directed || i == n_directed + RANDOM_ITEMS / 2) hold_req = 1'b1;
            send(byte_feed[i]);
        end
        s_valid = 1'b0;

        wait (tokens_owed == 0);
        repeat (DRAIN) @(posedge aclk);
        if (error_count == 0 && tokens_owed == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/fjst_pkg.sv
rtl/core/fjst_in_reg.sv
rtl/core/fjst_parser.sv
rtl/core/fjst_out_reg.sv
rtl/core/flat_json_string_tokenizer.sv
rtl/core/fjst_checker.sv
bench/fjst_token_checker.sv
bench/flat_json_string_tokenizer_test.sv
